>>> hdl/lfac_pkg.sv
// shared constants and types of the lru fully associative cache tag store
package lfac_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int unsigned INDEX_BITS  = 24;
  localparam int unsigned TAG_W       = INDEX_BITS;
  localparam int unsigned CNT_W       = 40;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned ACTIVE_W    = 7;
  localparam int unsigned MEMBLK_W    = 25;
  localparam int unsigned CFG_DATA_W  = 25;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [SHIFT_W-1:0]  SHIFT_MIN   = SHIFT_W'(2);
  localparam logic [SHIFT_W-1:0]  SHIFT_RST   = SHIFT_W'(6);
  localparam logic [ACTIVE_W-1:0] ACTIVE_MIN  = ACTIVE_W'(2);
  localparam logic [ACTIVE_W-1:0] ACTIVE_MAX  = ACTIVE_W'(MAX_ENTRIES);
  localparam logic [SLOT_W-1:0]   TOP_RANK_MAX = SLOT_W'(MAX_ENTRIES - 1);
  localparam logic [MEMBLK_W-1:0] MEMBLK_RST  = MEMBLK_W'(16777216);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_SHIFT     = 2'd0,
    REG_ACTIVE_ENTRIES = 2'd1,
    REG_MEM_BLOCKS     = 2'd2
  } cfg_reg_e;

  // control from the top level to the tag array
  typedef struct packed {
    logic              flush;
    logic              commit;
    logic [SLOT_W-1:0] top_rank;
  } tag_ctl_t;

  // lookup outcome for the block in the input register
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evict_valid;
    logic [TAG_W-1:0]  evicted_block;
  } lookup_t;

endpackage

>>> hdl/lru_fully_assoc_cache_tags.sv
// top level of the lru fully associative cache tag store
//
// usage:
//   input channel: word_index_i with in_valid_i / in_stall_o; a transfer
//   happens on a rising edge with valid high and stall low
//   output channel: one result per input, out_valid_o / out_stall_i, with
//   hit, slot, eviction, range error and the two running counters
//   config port: cfg_we_i, cfg_idx_i, cfg_wdata_i, one register per edge;
//   writing the line shift or the entry count invalidates every entry
// order: a word taken into the input register moves on to the result
//   register, which drives the outputs, once the result register is free
// throughput: one access per cycle unless the output stalls; tag compare,
//   lru pick and rank update all sit between input and result registers
// reset: all entries invalid, slot 0 is the oldest, counters at zero,
//   line shift 6, 64 active entries, 2^24 memory blocks
// stall: the result register holds its transfer; the input register keeps
//   one more word and then raises in_stall_o until the result is taken
module lru_fully_assoc_cache_tags (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config
  input  logic                             cfg_we_i,
  input  logic [lfac_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lfac_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lfac_pkg::INDEX_BITS-1:0]  word_index_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [lfac_pkg::SLOT_W-1:0]      slot_o,
  output logic                             evict_valid_o,
  output logic [lfac_pkg::TAG_W-1:0]       evicted_block_o,
  output logic                             range_error_o,
  output logic [lfac_pkg::CNT_W-1:0]       access_count_o,
  output logic [lfac_pkg::CNT_W-1:0]       miss_count_o
);
  import lfac_pkg::*;

  // config registers, stored already clamped
  logic [SHIFT_W-1:0]  shift_q;
  logic [SLOT_W-1:0]   top_rank_q;
  logic [MEMBLK_W-1:0] mem_blocks_q;
  logic                flush;

  // input register
  logic                  in_vld_q;
  logic [INDEX_BITS-1:0] word_q;

  // result register
  logic                  out_vld_q;
  logic                  hit_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  ev_q;
  logic [TAG_W-1:0]      evb_q;
  logic                  rerr_q;
  logic [CNT_W-1:0]      acc_q;
  logic [CNT_W-1:0]      miss_q;
  logic [CNT_W-1:0]      acc_d;
  logic [CNT_W-1:0]      miss_d;

  logic                  in_xfer;
  logic                  advance;
  logic [INDEX_BITS+1:0] byte_addr;
  logic [INDEX_BITS+1:0] blk_wide;
  logic [TAG_W-1:0]      blk;
  logic                  range_err;
  tag_ctl_t              ctl;
  lookup_t               look;
  logic [ACTIVE_W-1:0]   act_wr;

  // config writes
  assign act_wr = cfg_wdata_i[ACTIVE_W-1:0];
  always_comb begin
    flush = 1'b0;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_SHIFT:     flush = 1'b1;
        REG_ACTIVE_ENTRIES: flush = 1'b1;
        default:            flush = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= SHIFT_RST;
      top_rank_q   <= TOP_RANK_MAX;
      mem_blocks_q <= MEMBLK_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LINE_SHIFT: begin
          // shifts below a word act as a word
          shift_q <= (cfg_wdata_i[SHIFT_W-1:0] < SHIFT_MIN) ? SHIFT_MIN
                                                            : cfg_wdata_i[SHIFT_W-1:0];
        end
        REG_ACTIVE_ENTRIES: begin
          if (act_wr < ACTIVE_MIN)      top_rank_q <= SLOT_W'(ACTIVE_MIN - ACTIVE_W'(1));
          else if (act_wr > ACTIVE_MAX) top_rank_q <= TOP_RANK_MAX;
          else                          top_rank_q <= SLOT_W'(act_wr - ACTIVE_W'(1));
        end
        REG_MEM_BLOCKS:  mem_blocks_q <= cfg_wdata_i[MEMBLK_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the input register moves on when the result register is free
  assign advance    = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer)      in_vld_q <= 1'b1;
      else if (advance) in_vld_q <= 1'b0;
      if (advance)          out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) word_q <= word_index_i;
  end

  // block number of the word in the input register
  assign byte_addr = {word_q, 2'b00};
  assign blk_wide  = byte_addr >> shift_q;
  assign blk       = blk_wide[TAG_W-1:0];
  assign range_err = ({1'b0, blk} >= mem_blocks_q);

  assign ctl.flush    = flush;
  assign ctl.commit   = advance && !range_err;
  assign ctl.top_rank = top_rank_q;

  lfac_tag_array u_tags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .blk_i  (blk),
    .look_o (look)
  );

  // saturating counters, updated only by in-range accesses
  always_comb begin
    acc_d  = acc_q;
    miss_d = miss_q;
    if (!range_err) begin
      if (acc_q != '1) acc_d = acc_q + CNT_W'(1);
      if (!look.hit && (miss_q != '1)) miss_d = miss_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      miss_q <= '0;
    end else if (advance) begin
      acc_q  <= acc_d;
      miss_q <= miss_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      rerr_q <= range_err;
      hit_q  <= !range_err && look.hit;
      slot_q <= range_err ? '0 : look.slot;
      ev_q   <= !range_err && look.evict_valid;
      evb_q  <= range_err ? '0 : look.evicted_block;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evict_valid_o   = ev_q;
  assign evicted_block_o = evb_q;
  assign range_error_o   = rerr_q;
  assign access_count_o  = acc_q;
  assign miss_count_o    = miss_q;

endmodule

>>> hdl/lfac_tag_array.sv
// tag, valid and recency storage with parallel compare and lru update
module lfac_tag_array (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfac_pkg::tag_ctl_t       ctl_i,
  input  logic [lfac_pkg::TAG_W-1:0] blk_i,
  output lfac_pkg::lookup_t        look_o
);
  import lfac_pkg::*;

  logic [TAG_W-1:0]  tag_q  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [SLOT_W-1:0] rank_q [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] active;
  logic [MAX_ENTRIES-1:0] match_oh;
  logic [MAX_ENTRIES-1:0] lru_oh;
  logic [MAX_ENTRIES-1:0] sel_oh;
  logic                   hit;
  logic [SLOT_W-1:0]      sel_slot;
  logic [SLOT_W-1:0]      hit_rank;
  logic [SLOT_W-1:0]      pivot;
  logic [TAG_W-1:0]       victim_tag;
  logic                   victim_valid;

  // ranks among active slots form a permutation of 0..top_rank; rank 0 is lru
  always_comb begin
    hit_rank     = '0;
    sel_slot     = '0;
    victim_tag   = '0;
    victim_valid = 1'b0;
    for (int s = 0; s < MAX_ENTRIES; s++) begin
      active[s]   = (SLOT_W'(s) <= ctl_i.top_rank);
      match_oh[s] = active[s] && valid_q[s] && (tag_q[s] == blk_i);
      lru_oh[s]   = active[s] && (rank_q[s] == '0);
    end
    hit    = |match_oh;
    sel_oh = hit ? match_oh : lru_oh;
    for (int s = 0; s < MAX_ENTRIES; s++) begin
      if (match_oh[s]) hit_rank = hit_rank | rank_q[s];
      if (sel_oh[s])   sel_slot = sel_slot | SLOT_W'(s);
      if (lru_oh[s]) begin
        victim_tag   = victim_tag | tag_q[s];
        victim_valid = victim_valid | valid_q[s];
      end
    end
    pivot = hit ? hit_rank : '0;
  end

  assign look_o.hit           = hit;
  assign look_o.slot          = sel_slot;
  assign look_o.evict_valid   = !hit && victim_valid;
  assign look_o.evicted_block = (!hit && victim_valid) ? victim_tag : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int s = 0; s < MAX_ENTRIES; s++) rank_q[s] <= SLOT_W'(s);
    end else if (ctl_i.flush) begin
      valid_q <= '0;
      for (int s = 0; s < MAX_ENTRIES; s++) rank_q[s] <= SLOT_W'(s);
    end else if (ctl_i.commit) begin
      for (int s = 0; s < MAX_ENTRIES; s++) begin
        if (sel_oh[s]) begin
          rank_q[s]  <= ctl_i.top_rank;
          valid_q[s] <= 1'b1;
        end else if (active[s] && (rank_q[s] > pivot)) begin
          rank_q[s] <= rank_q[s] - SLOT_W'(1);
        end
      end
    end
  end

  // tags carry no reset, only read behind a valid bit
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && !ctl_i.flush && !hit) begin
      for (int s = 0; s < MAX_ENTRIES; s++) begin
        if (lru_oh[s]) tag_q[s] <= blk_i;
      end
    end
  end

endmodule

>>> hdl/lfac_checker.sv
// port-level checks for the cache tag store, bound to the top level
module lfac_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             hit_o,
  input logic [lfac_pkg::SLOT_W-1:0]      slot_o,
  input logic                             evict_valid_o,
  input logic [lfac_pkg::TAG_W-1:0]       evicted_block_o,
  input logic                             range_error_o,
  input logic [lfac_pkg::CNT_W-1:0]       access_count_o,
  input logic [lfac_pkg::CNT_W-1:0]       miss_count_o
);
  import lfac_pkg::*;

  // a stalled result transfer holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_o) && $stable(hit_o)
      && $stable(evicted_block_o) && $stable(access_count_o))
    else $error("result changed while stalled");

  // rejected access reports no slot and no eviction
  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> !hit_o && !evict_valid_o && (slot_o == '0)
      && (evicted_block_o == '0))
    else $error("range error with lookup result");

  // eviction only on a miss
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evict_valid_o |-> !hit_o)
    else $error("eviction reported on a hit");

  // misses never outnumber accesses
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> miss_count_o <= access_count_o)
    else $error("miss count above access count");

endmodule

bind lru_fully_assoc_cache_tags lfac_checker u_lfac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .hit_o           (hit_o),
  .slot_o          (slot_o),
  .evict_valid_o   (evict_valid_o),
  .evicted_block_o (evicted_block_o),
  .range_error_o   (range_error_o),
  .access_count_o  (access_count_o),
  .miss_count_o    (miss_count_o)
);

>>> tb/sv/lru_fully_assoc_cache_tags_tb.sv
// self-checking testbench of the lru cache tag store: directed table then random access traffic
`timescale 1ns / 1ps

module lru_fully_assoc_cache_tags_tb;
  import lfac_pkg::*;

  // register index that the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 73;
  localparam int unsigned DIR_ROWS = 35;

  // one lookup result as the block reports it
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evict_valid;
    logic [TAG_W-1:0]  evicted_block;
    logic              range_error;
    logic [CNT_W-1:0]  access_count;
    logic [CNT_W-1:0]  miss_count;
  } lookup_result_t;

  typedef enum logic {ROW_WRITE, ROW_ACCESS} row_kind_e;

  // directed row: a register write, or an access with an optional typed-in result
  // (counters always come from the predictor)
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  value;
    logic [INDEX_BITS-1:0]  word;
    logic                   typed;
    logic                   hit;
    logic [SLOT_W-1:0]      slot;
    logic                   evict_valid;
    logic [TAG_W-1:0]       evicted_block;
    logic                   range_error;
  } dir_row_t;

  // reset state first, then the entry count clamp, the small shift clamp, range errors,
  // a shift that folds every word into block 0, zero memory blocks and an ignored index
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000000, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h00000F, 1'b1, 1'b1, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000010, 1'b1, 1'b0, 6'd1, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'hFFFFFF, 1'b1, 1'b0, 6'd2, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_ACTIVE_ENTRIES, 25'h0, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000000, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000010, 1'b1, 1'b0, 6'd1, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000020, 1'b1, 1'b0, 6'd0, 1'b1, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000010, 1'b1, 1'b1, 6'd1, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000030, 1'b1, 1'b0, 6'd0, 1'b1, 24'h2, 1'b0},
    '{ROW_WRITE, REG_LINE_SHIFT, 25'h0, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_MEM_BLOCKS, 25'h1, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000001, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b1},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000000, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'hFFFFFF, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b1},
    '{ROW_WRITE, REG_MEM_BLOCKS, 25'h1FFFFFF, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_LINE_SHIFT, 25'h1F, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_ACTIVE_ENTRIES, 25'h7F, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'hFFFFFF, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000000, 1'b1, 1'b1, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_LINE_SHIFT, 25'h2, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_ACTIVE_ENTRIES, 25'h40, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_MEM_BLOCKS, 25'h1000000, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'hFFFFFF, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h800000, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_MEM_BLOCKS, 25'h0, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h000000, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b1},
    '{ROW_WRITE, REG_SPARE, 25'h1FFFFFF, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h123456, 1'b1, 1'b0, 6'd0, 1'b0, 24'h0, 1'b1},
    '{ROW_WRITE, REG_MEM_BLOCKS, 25'h1000000, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_LINE_SHIFT, 25'h10, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_ACTIVE_ENTRIES, 25'h2, 24'h0, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h00ABCD, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h7FC000, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0},
    '{ROW_ACCESS, REG_LINE_SHIFT, 25'h0, 24'h03FFFF, 1'b0, 1'b0, 6'd0, 1'b0, 24'h0, 1'b0}
  };

  // dut signals; the inputs are all known from time zero
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [INDEX_BITS-1:0] word_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [SLOT_W-1:0]     slot_o;
  logic                  evict_valid_o;
  logic [TAG_W-1:0]      evicted_block_o;
  logic                  range_error_o;
  logic [CNT_W-1:0]      access_count_o;
  logic [CNT_W-1:0]      miss_count_o;

  // random idling on both sides, switched off for one whole phase
  logic gaps_on = 1'b1;
  int unsigned mismatches = 0;

  // lookups accepted by the block whose results are still on their way
  lookup_result_t pending_lookups[$];

  // predictor copy of the tag store and its registers
  logic [TAG_W-1:0]    cached_block [MAX_ENTRIES];
  logic                line_valid [MAX_ENTRIES];
  logic [SLOT_W-1:0]   age_rank [MAX_ENTRIES];
  logic [CNT_W-1:0]    seen_accesses;
  logic [CNT_W-1:0]    seen_misses;
  logic [SHIFT_W-1:0]  cur_shift;
  logic [ACTIVE_W-1:0] cur_active;
  logic [MEMBLK_W-1:0] cur_mem_blocks;

  lru_fully_assoc_cache_tags uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .word_index_i    (word_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evict_valid_o   (evict_valid_o),
    .evicted_block_o (evicted_block_o),
    .range_error_o   (range_error_o),
    .access_count_o  (access_count_o),
    .miss_count_o    (miss_count_o)
  );

  always #2 clk_i = ~clk_i;

  // invalidate every line and put slot 0 back at the bottom of the recency order
  function automatic void clear_lines();
    for (int s = 0; s < MAX_ENTRIES; s++) begin
      cached_block[s] = '0;
      line_valid[s] = 1'b0;
      age_rank[s] = SLOT_W'(s);
    end
  endfunction

  function automatic int unsigned eff_shift();
    return (cur_shift < SHIFT_MIN) ? 2 : int'(cur_shift);
  endfunction

  // tag lookup with lru replacement, updating the predictor state
  function automatic lookup_result_t lookup_block(logic [INDEX_BITS-1:0] word);
    lookup_result_t res;
    longint unsigned blk;
    int unsigned n;
    int unsigned way;
    logic found;
    logic [SLOT_W-1:0] old_rank;
    res = '0;
    blk = (64'(word) << 2) >> eff_shift();
    n = (cur_active < ACTIVE_MIN) ? 2 : (cur_active > ACTIVE_MAX) ? MAX_ENTRIES
        : int'(cur_active);
    // out of range: nothing moves, counters reported as they stand
    if (blk >= 64'(cur_mem_blocks)) begin
      res.range_error = 1'b1;
      res.access_count = seen_accesses;
      res.miss_count = seen_misses;
      return res;
    end
    if (seen_accesses != '1) seen_accesses++;
    found = 1'b0;
    way = 0;
    for (int s = 0; s < n; s++) begin
      if (!found && line_valid[s] && 64'(cached_block[s]) == blk) begin
        found = 1'b1;
        way = s;
      end
    end
    if (!found) begin
      // victim is the lowest rank among the active lines
      for (int s = 1; s < n; s++) begin
        if (age_rank[s] < age_rank[way]) way = s;
      end
      if (line_valid[way]) begin
        res.evict_valid = 1'b1;
        res.evicted_block = cached_block[way];
      end
      cached_block[way] = TAG_W'(blk);
      line_valid[way] = 1'b1;
      if (seen_misses != '1) seen_misses++;
    end
    old_rank = age_rank[way];
    for (int s = 0; s < MAX_ENTRIES; s++) begin
      if (age_rank[s] > old_rank) age_rank[s]--;
    end
    age_rank[way] = TOP_RANK_MAX;
    res.hit = found;
    res.slot = SLOT_W'(way);
    res.access_count = seen_accesses;
    res.miss_count = seen_misses;
    return res;
  endfunction

  // some word that falls in the given block under the current shift
  function automatic logic [INDEX_BITS-1:0] word_for_block(longint unsigned blk);
    int unsigned wsh;
    wsh = eff_shift() - 2;
    if (wsh >= INDEX_BITS) return INDEX_BITS'($urandom);
    return INDEX_BITS'((blk << wsh) | (64'($urandom) & ((64'd1 << wsh) - 1)));
  endfunction

  // let the result queue empty out, then give the pipeline time to settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write, only issued with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LINE_SHIFT: begin
        cur_shift = val[SHIFT_W-1:0];
        clear_lines();
      end
      REG_ACTIVE_ENTRIES: begin
        cur_active = val[ACTIVE_W-1:0];
        clear_lines();
      end
      REG_MEM_BLOCKS: begin
        cur_mem_blocks = val[MEMBLK_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one input transfer; valid stays up afterwards unless a gap follows
  task automatic send_word(logic [INDEX_BITS-1:0] word, output lookup_result_t res);
    while (gaps_on && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_index_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = lookup_block(word);
  endtask

  function automatic void compare_field(string fname, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // receiver side stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= gaps_on && ($urandom_range(99) < 17);
  end

  // result checker: every output transfer against the oldest pending lookup
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: result transfer with nothing pending, expected none actual slot %0d",
                 $time, slot_o);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        compare_field("hit", want.hit, hit_o);
        compare_field("slot", want.slot, slot_o);
        compare_field("evict_valid", want.evict_valid, evict_valid_o);
        compare_field("evicted_block", want.evicted_block, evicted_block_o);
        compare_field("range_error", want.range_error, range_error_o);
        compare_field("access_count", want.access_count, access_count_o);
        compare_field("miss_count", want.miss_count, miss_count_o);
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    lookup_result_t res;
    dir_row_t row;
    longint unsigned hot_blocks [128];
    longint unsigned lim;
    longint unsigned blk;
    int unsigned pool_n;
    int unsigned n_act;
    int unsigned eff;
    int unsigned sel;
    logic [SHIFT_W-1:0] p_shift;
    logic [ACTIVE_W-1:0] p_active;
    logic [MEMBLK_W-1:0] p_mem;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_LINE_SHIFT;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    word_index_i = '0;

    // predictor reset values
    cur_shift = SHIFT_RST;
    cur_active = ACTIVE_MAX;
    cur_mem_blocks = MEMBLK_RST;
    seen_accesses = '0;
    seen_misses = '0;
    clear_lines();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      if (row.kind == ROW_WRITE) begin
        write_reg(row.reg_idx, row.value);
      end else begin
        send_word(row.word, res);
        // typed rows fix the lookup outcome; counters still come from the predictor
        if (row.typed) begin
          res.hit = row.hit;
          res.slot = row.slot;
          res.evict_valid = row.evict_valid;
          res.evicted_block = row.evicted_block;
          res.range_error = row.range_error;
        end
        pending_lookups.push_back(res);
      end
    end

    // random phases: new settings each time, then traffic mostly over a hot set
    // sized around the active entry count so hits, fills and evictions all happen
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin p_shift = 5'd2; p_active = 7'd2; end
        2: begin p_shift = 5'd16; p_active = 7'd64; end
        3: begin p_shift = 5'd31; p_active = 7'($urandom_range(2, 16)); end
        4: begin p_shift = 5'($urandom_range(0, 1)); p_active = 7'd0; end
        5: begin p_shift = 5'($urandom_range(2, 12)); p_active = 7'd127; end
        default: begin
          p_shift = ($urandom_range(99) < 70) ? 5'($urandom_range(2, 12))
                    : 5'($urandom_range(0, 31));
          p_active = ($urandom_range(1) != 0) ? 7'($urandom_range(2, 16))
                     : 7'($urandom_range(0, 127));
        end
      endcase
      case (ph)
        6: p_mem = 25'($urandom_range(1, 64));
        7: p_mem = 25'h1FFFFFF;
        default: p_mem = ($urandom_range(1) != 0) ? MEMBLK_RST
                         : 25'($urandom_range(1, 32'h1FFFFFF));
      endcase
      write_reg(REG_LINE_SHIFT, CFG_DATA_W'(p_shift));
      write_reg(REG_ACTIVE_ENTRIES, CFG_DATA_W'(p_active));
      write_reg(REG_MEM_BLOCKS, CFG_DATA_W'(p_mem));
      gaps_on <= (ph != 1);

      eff = eff_shift();
      if (eff > 26) eff = 26;
      lim = 64'd1 << (26 - eff);
      if (64'(p_mem) < lim) lim = 64'(p_mem);
      n_act = (p_active < ACTIVE_MIN) ? 2 : (p_active > ACTIVE_MAX) ? MAX_ENTRIES
              : int'(p_active);
      pool_n = n_act + $urandom_range(0, n_act);
      for (int i = 0; i < pool_n; i++) hot_blocks[i] = $urandom_range(0, 32'(lim - 1));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold the sender until the output side has caught up
        if (ph == 3 && k == 36) wait_drained();
        sel = $urandom_range(99);
        if (sel < 75) begin
          blk = hot_blocks[$urandom_range(0, pool_n - 1)];
          send_word(word_for_block(blk), res);
        end else if (sel < 90) begin
          send_word(INDEX_BITS'($urandom), res);
        end else begin
          // right at the memory limit, one side or the other
          blk = 64'(p_mem) - 1 + $urandom_range(0, 1);
          if (blk >= (64'd1 << (26 - eff))) send_word(INDEX_BITS'($urandom), res);
          else send_word(word_for_block(blk), res);
        end
        pending_lookups.push_back(res);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> lru_fully_assoc_cache_tags.f
hdl/lfac_pkg.sv
hdl/lfac_tag_array.sv
hdl/lru_fully_assoc_cache_tags.sv
hdl/lfac_checker.sv
tb/sv/lru_fully_assoc_cache_tags_tb.sv
